// ===== sv/dirty_rect_merge_table_top_assert.svh =====
// Assertion macros for the dirty rectangle merge table.
// Used by dirty_rect_merge_table_top only.
`ifndef DIRTY_RECT_MERGE_TABLE_TOP_ASSERT_SVH
`define DIRTY_RECT_MERGE_TABLE_TOP_ASSERT_SVH
`define DRMT_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("drmt check failed");
`define DRMT_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("drmt check failed");
`endif

// ===== sv/drmt_pkg.sv =====
// Package for the dirty rectangle merge table.
// Types, constants and rectangle helper functions; no dependencies.
package drmt_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned RectW = 128;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_ABS_RDK, ST_ABS_RD, ST_ABS_CHK,
    ST_SHIFT_RD, ST_SHIFT_WR, ST_READ_WAIT, ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] h;
    logic [31:0] w;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } rect_t;

  // Saturating end of a span.
  function automatic logic signed [32:0] end_of(logic signed [31:0] s, logic [31:0] e);
    logic signed [33:0] t;
    t = 34'(s) + $signed({2'b00, e});
    end_of = (t > 34'sd2147483647) ? 33'sd2147483647 : t[32:0];
  endfunction

  function automatic logic touches(rect_t a, rect_t b);
    logic ok;
    ok = (a.w != 0) && (a.h != 0) && (b.w != 0) && (b.h != 0);
    touches = ok && (33'(a.x) <= end_of(b.x, b.w)) && (33'(b.x) <= end_of(a.x, a.w))
              && (33'(a.y) <= end_of(b.y, b.h)) && (33'(b.y) <= end_of(a.y, a.h));
  endfunction

  // Union of b into a; a unchanged if either is empty.
  function automatic rect_t unite(rect_t a, rect_t b);
    logic signed [31:0] x0, y0;
    logic signed [32:0] x1, y1, ea, eb;
    rect_t r;
    r = a;
    if (a.w != 0 && a.h != 0 && b.w != 0 && b.h != 0) begin
      x0 = (a.x < b.x) ? a.x : b.x;
      y0 = (a.y < b.y) ? a.y : b.y;
      ea = end_of(a.x, a.w);
      eb = end_of(b.x, b.w);
      x1 = (eb > ea) ? eb : ea;
      ea = end_of(a.y, a.h);
      eb = end_of(b.y, b.h);
      y1 = (eb > ea) ? eb : ea;
      r.x = x0;
      r.y = y0;
      r.w = 32'(x1 - 33'(x0));
      r.h = 32'(y1 - 33'(y0));
    end
    unite = r;
  endfunction
endpackage

// ===== sv/drmt_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module drmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/dirty_rect_merge_table_top.sv =====
// Dirty rectangle merge table: one result per command item.
// Mark, clear and read finish without a table scan; append scans the table and,
// when merging, makes neighbour passes that shift and absorb entries.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is taken. The table RAM's single read port sets the pace.
// Reset: async active low; count zero, full-redraw pending set, RAM not cleared.
// Depends on drmt_pkg, drmt_ram and dirty_rect_merge_table_top_assert.svh.
`include "dirty_rect_merge_table_top_assert.svh"
module dirty_rect_merge_table_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], rect_x[33:2], rect_y[65:34], rect_width[97:66],
  // rect_height[129:98], read_index[133:130], zero pad to 136
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accepted[0], changed[1], entry_count[6:2], full_pending[7], read_valid[8],
  // out_x[40:9], out_y[72:41], out_width[104:73], out_height[136:105], pad to 144
  output logic [143:0] m_axis_tdata
);
  localparam int unsigned IW = drmt_pkg::IdxW;
  localparam int unsigned CW = drmt_pkg::CntW;

  drmt_pkg::state_e state_q, state_d;
  logic [1:0]   cmd_q, cmd_d;
  drmt_pkg::rect_t rin_q, rin_d, kr_q, kr_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, k_q, k_d, j_q, j_d;
  logic         flag_q, flag_d, acc_q, acc_d, chg_q, chg_d;
  logic         ov_q, ov_d;
  logic [143:0] od_q, od_d;

  logic         we;
  logic [IW-1:0] waddr, raddr;
  drmt_pkg::rect_t wdata, rdata, u;

  drmt_ram #(.Width(drmt_pkg::RectW), .Depth(drmt_pkg::TableDepth)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == drmt_pkg::ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drmt_pkg::ST_IDLE;
      cnt_q   <= '0;
      flag_q  <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      flag_q  <= flag_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; rin_q <= rin_d; kr_q <= kr_d; ridx_q <= ridx_d;
    i_q <= i_d; k_q <= k_d; j_q <= j_d; acc_q <= acc_d; chg_q <= chg_d;
    od_q <= od_d;
  end

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; rin_d = rin_q; kr_d = kr_q;
    ridx_d = ridx_q; cnt_d = cnt_q; i_d = i_q; k_d = k_q; j_d = j_q;
    flag_d = flag_q; acc_d = acc_q; chg_d = chg_q; ov_d = ov_q; od_d = od_q;
    we = 1'b0; waddr = k_q[IW-1:0]; wdata = kr_q; raddr = i_q[IW-1:0];
    u = drmt_pkg::unite(rdata, rin_q);
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (state_q)
      drmt_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d = s_axis_tdata[1:0];
          rin_d = s_axis_tdata[129:2];
          ridx_d = s_axis_tdata[133:130];
          acc_d = 1'b0; chg_d = 1'b0; i_d = '0;
          unique case (drmt_pkg::cmd_e'(s_axis_tdata[1:0]))
            drmt_pkg::CMD_APPEND: begin
              if (s_axis_tdata[97:66] == 0 || s_axis_tdata[129:98] == 0)
                state_d = drmt_pkg::ST_DONE;
              else state_d = drmt_pkg::ST_SCAN_RD;
            end
            drmt_pkg::CMD_MARK: begin
              cnt_d = '0; flag_d = 1'b1; state_d = drmt_pkg::ST_DONE;
            end
            drmt_pkg::CMD_CLEAR: begin
              cnt_d = '0; flag_d = 1'b0; state_d = drmt_pkg::ST_DONE;
            end
            drmt_pkg::CMD_READ: begin
              raddr = s_axis_tdata[133:130];
              state_d = drmt_pkg::ST_READ_WAIT;
            end
            default: state_d = drmt_pkg::ST_DONE;
          endcase
        end
      end
      drmt_pkg::ST_SCAN_RD: begin
        if (i_q >= cnt_q) begin
          if (cnt_q >= CW'(drmt_pkg::TableDepth)) begin
            flag_d = 1'b1;
          end else begin
            we = 1'b1; waddr = cnt_q[IW-1:0]; wdata = rin_q;
            cnt_d = cnt_q + 1'b1; acc_d = 1'b1; chg_d = 1'b1;
          end
          state_d = drmt_pkg::ST_DONE;
        end else state_d = drmt_pkg::ST_SCAN_CHK;
      end
      drmt_pkg::ST_SCAN_CHK: begin
        if (drmt_pkg::touches(rdata, rin_q)) begin
          acc_d = 1'b1;
          if (u != rdata) begin
            chg_d = 1'b1; we = 1'b1; waddr = i_q[IW-1:0]; wdata = u;
            kr_d = u; k_d = i_q; i_d = '0;
            state_d = drmt_pkg::ST_ABS_RD;
          end else state_d = drmt_pkg::ST_DONE;
        end else begin
          i_d = i_q + 1'b1; state_d = drmt_pkg::ST_SCAN_RD;
        end
      end
      drmt_pkg::ST_ABS_RD: begin
        if (i_q >= cnt_q || k_q >= cnt_q) state_d = drmt_pkg::ST_DONE;
        else if (i_q == k_q) i_d = i_q + 1'b1;
        else state_d = drmt_pkg::ST_ABS_CHK;
      end
      drmt_pkg::ST_ABS_CHK: begin
        if (drmt_pkg::touches(kr_q, rdata)) begin
          kr_d = drmt_pkg::unite(kr_q, rdata);
          if (i_q < k_q) k_d = k_q - 1'b1;
          j_d = i_q;
          state_d = drmt_pkg::ST_SHIFT_RD;
        end else begin
          i_d = i_q + 1'b1; state_d = drmt_pkg::ST_ABS_RD;
        end
      end
      drmt_pkg::ST_SHIFT_RD: begin
        if (j_q + 1'b1 < cnt_q) begin
          raddr = IW'(j_q + 1'b1); state_d = drmt_pkg::ST_SHIFT_WR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          state_d = drmt_pkg::ST_ABS_RDK;
        end
      end
      drmt_pkg::ST_SHIFT_WR: begin
        we = 1'b1; waddr = j_q[IW-1:0]; wdata = rdata;
        j_d = j_q + 1'b1; state_d = drmt_pkg::ST_SHIFT_RD;
      end
      drmt_pkg::ST_ABS_RDK: begin
        we = 1'b1; waddr = k_q[IW-1:0]; wdata = kr_q;
        i_d = '0; state_d = drmt_pkg::ST_ABS_RD;
      end
      drmt_pkg::ST_READ_WAIT: begin
        raddr = ridx_q;
        state_d = drmt_pkg::ST_DONE;
      end
      drmt_pkg::ST_DONE: begin
        if (!ov_d) begin
          od_d = '0;
          od_d[0] = acc_q; od_d[1] = chg_q; od_d[6:2] = 5'(cnt_q); od_d[7] = flag_q;
          if (cmd_q == drmt_pkg::CMD_READ && CW'(ridx_q) < cnt_q) begin
            od_d[8] = 1'b1; od_d[136:9] = rdata;
          end
          ov_d = 1'b1; state_d = drmt_pkg::ST_IDLE;
        end
      end
      default: state_d = drmt_pkg::ST_IDLE;
    endcase
  end

  `DRMT_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CW'(drmt_pkg::TableDepth))
  `DRMT_ASSERT_IMPL(a_no_acc_busy, state_q != drmt_pkg::ST_IDLE, !s_axis_tready)
  `DRMT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
